>>> rtl/rtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtu_pkg;

  // Fixed field widths of the advertisement and route channels.
  localparam int NODE_W     = 6;
  localparam int HOP_W      = 6;
  localparam int REL_W      = 2;
  localparam int ADV_COST_W = 8;
  localparam int OUT_COST_W = 8;

  // Default table geometry and cost ceiling.
  localparam int NODE_COUNT_DEF = 64;
  localparam int COST_MAX_DEF   = 255;

  // A route through a neighbour costs one more than that neighbour reports.
  localparam int COST_STEP = 1;

  // One route advertisement request.
  typedef struct packed {
    logic [NODE_W-1:0]     node_index;
    logic [HOP_W-1:0]      from_neighbour;
    logic [NODE_W-1:0]     dest_node;
    logic [ADV_COST_W-1:0] advertised_cost;
    logic [REL_W-1:0]      relation;
  } adv_t;

  // One route update result.
  typedef struct packed {
    logic                  announce;
    logic [NODE_W-1:0]     route_dest;
    logic [HOP_W-1:0]      route_next_hop;
    logic [REL_W-1:0]      route_relation;
    logic [OUT_COST_W-1:0] route_cost;
  } route_t;

endpackage

`default_nettype wire

>>> rtl/rtu_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Advertisement channel.
interface rtu_adv_if;
  import rtu_pkg::*;
  logic valid;
  logic ready;
  adv_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Route result channel.
interface rtu_route_if;
  import rtu_pkg::*;
  logic   valid;
  logic   ready;
  route_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rtu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/route_table_update_by_relation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Route table update unit.
// Each request on adv_i is one route advertisement received by node_index
// from from_neighbour for dest_node. The unit keeps one route entry per
// (node, destination) pair in a single-port-write RAM and returns exactly
// one result on route_o per request: the entry after the update and whether
// it was written (announce). Requests with node or destination outside the
// table return announce low and zero next hop, relation and cost.
// At the accepting edge the RAM is read and the request enters the
// compare stage; compare and write-back then load the output register
// once route_o can take a result. While route_o is not stalled the unit
// takes one request per cycle; back-to-back requests to the same entry
// are served by forwarding the last written entry around the RAM.
// After reset the unit clears the valid flag of every entry, one entry per
// cycle, NODE_COUNT * NODE_COUNT entries (4096 at the default size), and
// holds adv_i.ready low meanwhile.
// When the receiver stalls route_o, the result is held in the output
// register and one more request can wait in the compare stage; after that
// adv_i.ready goes low until route_o.ready returns.
module route_table_update_by_relation_unit #(
  parameter int NODE_COUNT = rtu_pkg::NODE_COUNT_DEF,
  parameter int COST_MAX   = rtu_pkg::COST_MAX_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rtu_adv_if.sink     adv_i,
  rtu_route_if.source route_o
);

  import rtu_pkg::*;

  localparam int DEPTH   = NODE_COUNT * NODE_COUNT;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CW      = $clog2(COST_MAX + 1);
  localparam int SUM_W   = (CW > ADV_COST_W + 1) ? CW : ADV_COST_W + 1;
  localparam int LIMIT_W = 11;
  localparam int PROD_W  = IDX_W + NODE_W + 1;

  typedef struct packed {
    logic             valid;
    logic [HOP_W-1:0] hop;
    logic [REL_W-1:0] rel;
    logic [CW-1:0]    cost;
  } entry_t;

  localparam int WORD_W = $bits(entry_t);

  // Clearing sweep after reset.
  logic             clearing_q, clearing_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  // Compare stage.
  logic             s1_valid_q, s1_valid_d;
  adv_t             s1_adv_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_inrange_q;

  // Forwarding of the last entry to leave the compare stage.
  logic             fwd_live_q, fwd_live_d;
  logic [IDX_W-1:0] fwd_idx_q;
  entry_t           fwd_word_q;

  // Output register.
  logic   out_valid_q, out_valid_d;
  route_t out_data_q, out_data_d;

  logic             out_can, s1_fire, in_fire, in_inrange;
  logic [IDX_W-1:0] in_idx;
  logic [PROD_W-1:0] prod;
  logic             upd;
  entry_t           cur_word, new_word, eff_word;
  logic [CW-1:0]    offer_cost;
  logic [SUM_W-1:0] cost_sum;
  logic [CW+OUT_COST_W-1:0] cost_ext;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Handshakes.
  assign out_can     = ~out_valid_q | route_o.ready;
  assign s1_fire     = s1_valid_q & out_can;
  assign adv_i.ready = ~clearing_q & (~s1_valid_q | out_can);
  assign in_fire     = adv_i.valid & adv_i.ready;

  // Table index and range check of the incoming request.
  assign prod = PROD_W'(adv_i.data.node_index) * PROD_W'(NODE_COUNT)
              + PROD_W'(adv_i.data.dest_node);
  assign in_idx = prod[IDX_W-1:0];
  assign in_inrange = (LIMIT_W'(adv_i.data.node_index) < LIMIT_W'(NODE_COUNT))
                    && (LIMIT_W'(adv_i.data.dest_node) < LIMIT_W'(NODE_COUNT));

  // Route table storage.
  rtu_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(in_idx),
    .rdata_o(ram_rdata)
  );

  // Route selection and result formatting.
  always_comb begin
    cur_word = (fwd_live_q && (fwd_idx_q == s1_idx_q)) ? fwd_word_q : entry_t'(ram_rdata);

    cost_sum = SUM_W'(s1_adv_q.advertised_cost) + SUM_W'(COST_STEP);
    if (cost_sum > SUM_W'(COST_MAX)) begin
      offer_cost = CW'(COST_MAX);
    end else begin
      offer_cost = CW'(cost_sum);
    end

    new_word.valid = 1'b1;
    new_word.hop   = s1_adv_q.from_neighbour;
    new_word.rel   = s1_adv_q.relation;
    new_word.cost  = offer_cost;

    if (!cur_word.valid) begin
      upd = 1'b1;
    end else if (s1_adv_q.relation < cur_word.rel) begin
      upd = 1'b1;
    end else if (s1_adv_q.relation == cur_word.rel) begin
      upd = (offer_cost < cur_word.cost) || (cur_word.hop == s1_adv_q.from_neighbour);
    end else begin
      upd = 1'b0;
    end
    upd = upd & s1_inrange_q;

    eff_word = upd ? new_word : cur_word;
    cost_ext = (CW + OUT_COST_W)'(eff_word.cost);

    out_data_d.announce   = upd;
    out_data_d.route_dest = s1_adv_q.dest_node;
    if (s1_inrange_q) begin
      out_data_d.route_next_hop = eff_word.hop;
      out_data_d.route_relation = eff_word.rel;
      out_data_d.route_cost     = cost_ext[OUT_COST_W-1:0];
    end else begin
      out_data_d.route_next_hop = '0;
      out_data_d.route_relation = '0;
      out_data_d.route_cost     = '0;
    end
  end

  // Write port: clearing sweep first, then route updates.
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire & upd;
      ram_waddr = s1_idx_q;
      ram_wdata = WORD_W'(new_word);
    end
  end

  // Next state of the control registers.
  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end

    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (route_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    // A request read in the same cycle as a write-back saw the RAM before
    // that write; the flag stays with the request while it waits.
    if (in_fire) begin
      fwd_live_d = s1_fire & s1_inrange_q;
    end else begin
      fwd_live_d = fwd_live_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_live_q  <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_idx_q   <= clr_idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      fwd_live_q  <= fwd_live_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_adv_q     <= adv_i.data;
      s1_idx_q     <= in_idx;
      s1_inrange_q <= in_inrange;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
      fwd_idx_q  <= s1_idx_q;
      fwd_word_q <= eff_word;
    end
  end

  assign route_o.valid = out_valid_q;
  assign route_o.data  = out_data_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_route_table_update_by_relation_unit.sv
`timescale 1ns / 1ps

module tb_route_table_update_by_relation_unit;
  import rtu_pkg::*;

  localparam int TABLE_DEPTH    = NODE_COUNT_DEF * NODE_COUNT_DEF;
  localparam int DIRECTED_ROWS  = 23;
  localparam int RANDOM_ADVERTS = 630;
  localparam int MAX_IDLE       = 19;
  localparam int DRAIN_CYCLES   = 8;

  // Relation classes; zero is outside the normal range but compares as best.
  localparam logic [REL_W-1:0] REL_RAW_ZERO = 2'd0;
  localparam logic [REL_W-1:0] REL_BEST     = 2'd1;
  localparam logic [REL_W-1:0] REL_MID      = 2'd2;
  localparam logic [REL_W-1:0] REL_WORST    = 2'd3;

  typedef struct {
    adv_t   adv;
    bit     typed;
    route_t route;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rtu_adv_if   adv_ch ();
  rtu_route_if route_ch ();

  route_table_update_by_relation_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_ch),
    .route_o(route_ch)
  );

  // Shadow route table, indexed by {node, destination}.
  bit                    tbl_valid [TABLE_DEPTH];
  logic [HOP_W-1:0]      tbl_hop   [TABLE_DEPTH];
  logic [REL_W-1:0]      tbl_rel   [TABLE_DEPTH];
  logic [OUT_COST_W-1:0] tbl_cost  [TABLE_DEPTH];

  route_t pending_routes [$];

  int errors       = 0;
  int sent         = 0;
  int results_seen = 0;
  int announced    = 0;
  bit send_burst   = 1'b1;
  bit recv_burst   = 1'b0;

  always #2 clk_i = ~clk_i;

  // Apply one advertisement to the shadow table and return the route result.
  function automatic route_t select_route(input adv_t a);
    route_t r;
    int     idx;
    int     offered;
    bit     take;
    r = '0;
    r.route_dest = a.dest_node;
    if (a.node_index >= NODE_COUNT_DEF || a.dest_node >= NODE_COUNT_DEF) begin
      return r;
    end
    idx = a.node_index * NODE_COUNT_DEF + a.dest_node;
    offered = int'(a.advertised_cost) + COST_STEP;
    if (offered > COST_MAX_DEF) begin
      offered = COST_MAX_DEF;
    end
    take = !tbl_valid[idx] || a.relation < tbl_rel[idx] ||
           (a.relation == tbl_rel[idx] &&
            (offered < tbl_cost[idx] || tbl_hop[idx] == a.from_neighbour));
    if (take) begin
      tbl_valid[idx] = 1'b1;
      tbl_hop[idx]   = a.from_neighbour;
      tbl_rel[idx]   = a.relation;
      tbl_cost[idx]  = offered[OUT_COST_W-1:0];
    end
    r.announce       = take;
    r.route_next_hop = tbl_hop[idx];
    r.route_relation = tbl_rel[idx];
    r.route_cost     = tbl_cost[idx];
    return r;
  endfunction

  // Build one row of the directed table; the route fields count only if typed.
  function automatic stim_row_t mk_row(input int node, input int from, input int dest,
                                       input int cost, input logic [REL_W-1:0] rel,
                                       input bit typed, input bit ann, input int hop,
                                       input logic [REL_W-1:0] rrel, input int rcost);
    stim_row_t s;
    s.adv.node_index      = node[NODE_W-1:0];
    s.adv.from_neighbour  = from[HOP_W-1:0];
    s.adv.dest_node       = dest[NODE_W-1:0];
    s.adv.advertised_cost = cost[ADV_COST_W-1:0];
    s.adv.relation        = rel;
    s.typed               = typed;
    s.route.announce       = ann;
    s.route.route_dest     = dest[NODE_W-1:0];
    s.route.route_next_hop = hop[HOP_W-1:0];
    s.route.route_relation = rrel;
    s.route.route_cost     = rcost[OUT_COST_W-1:0];
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Drive one request; called at a falling edge and returns at a falling edge.
  task automatic send_advert(input adv_t a, input bit typed, input route_t fixed);
    int     gap;
    route_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      adv_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    adv_ch.valid <= 1'b1;
    adv_ch.data  <= a;
    do @(posedge clk_i); while (adv_ch.ready !== 1'b1);
    predicted = select_route(a);
    pending_routes.push_back(typed ? fixed : predicted);
    sent++;
    if (sent % 64 == 0) begin
      send_burst = ($urandom_range(0, 3) == 0);
    end
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed table, then random advertisements.
  initial begin
    stim_row_t dir_rows [DIRECTED_ROWS];
    adv_ch.valid = 1'b0;
    adv_ch.data  = '0;
    dir_rows = '{
      // One entry walked through new, no change, refresh, lower cost,
      // better relation, worse relation, relation zero and saturation.
      mk_row(0, 5, 0, 0, REL_WORST, 1, 1, 5, REL_WORST, 1),
      mk_row(0, 6, 0, 10, REL_WORST, 1, 0, 5, REL_WORST, 1),
      mk_row(0, 5, 0, 20, REL_WORST, 1, 1, 5, REL_WORST, 21),
      mk_row(0, 7, 0, 0, REL_WORST, 1, 1, 7, REL_WORST, 1),
      mk_row(0, 8, 0, 200, REL_MID, 1, 1, 8, REL_MID, 201),
      mk_row(0, 9, 0, 0, REL_WORST, 1, 0, 8, REL_MID, 201),
      mk_row(0, 10, 0, 255, REL_RAW_ZERO, 1, 1, 10, REL_RAW_ZERO, 255),
      mk_row(0, 11, 0, 254, REL_RAW_ZERO, 1, 0, 10, REL_RAW_ZERO, 255),
      mk_row(0, 10, 0, 254, REL_RAW_ZERO, 1, 1, 10, REL_RAW_ZERO, 255),
      // Top corner of the table and saturated costs.
      mk_row(63, 63, 63, 255, REL_WORST, 1, 1, 63, REL_WORST, 255),
      mk_row(63, 0, 63, 254, REL_WORST, 1, 0, 63, REL_WORST, 255),
      mk_row(63, 0, 63, 253, REL_WORST, 1, 1, 0, REL_WORST, 254),
      mk_row(63, 1, 63, 100, REL_BEST, 1, 1, 1, REL_BEST, 101),
      // Alternating bit patterns and the remaining corners.
      mk_row(42, 21, 21, 85, REL_MID, 1, 1, 21, REL_MID, 86),
      mk_row(21, 42, 42, 170, REL_BEST, 1, 1, 42, REL_BEST, 171),
      mk_row(0, 0, 63, 0, REL_RAW_ZERO, 1, 1, 0, REL_RAW_ZERO, 1),
      mk_row(63, 32, 0, 127, REL_MID, 1, 1, 32, REL_MID, 128),
      // Back-to-back updates of one entry, checked by the predictor.
      mk_row(5, 1, 5, 30, REL_MID, 0, 0, 0, REL_RAW_ZERO, 0),
      mk_row(5, 2, 5, 10, REL_MID, 0, 0, 0, REL_RAW_ZERO, 0),
      mk_row(5, 2, 5, 50, REL_MID, 0, 0, 0, REL_RAW_ZERO, 0),
      mk_row(5, 3, 5, 40, REL_MID, 0, 0, 0, REL_RAW_ZERO, 0),
      mk_row(5, 4, 5, 40, REL_BEST, 0, 0, 0, REL_RAW_ZERO, 0),
      mk_row(5, 1, 5, 0, REL_WORST, 0, 0, 0, REL_RAW_ZERO, 0)
    };
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_advert(dir_rows[i].adv, dir_rows[i].typed, dir_rows[i].route);
    end

    // Most requests hit a small pool of entries and neighbours so that
    // refreshes, cost races and relation changes happen often.
    for (int n = 0; n < RANDOM_ADVERTS; n++) begin
      adv_t a;
      int   pick;
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        a.node_index     = NODE_W'($urandom_range(0, 3));
        a.dest_node      = NODE_W'($urandom_range(0, 3));
        a.from_neighbour = HOP_W'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
          0: begin
            a.advertised_cost = '0;
          end
          1: begin
            a.advertised_cost = ADV_COST_W'($urandom_range(253, 255));
          end
          default: begin
            a.advertised_cost = ADV_COST_W'($urandom_range(0, 40));
          end
        endcase
        a.relation = ($urandom_range(0, 19) == 0) ? REL_RAW_ZERO
                                                  : REL_W'($urandom_range(1, 3));
      end else begin
        a = adv_t'($urandom);
      end
      send_advert(a, 1'b0, '0);
    end
    adv_ch.valid <= 1'b0;

    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d advertisements sent, %0d routes checked: %0d announced, %0d unchanged",
             sent, results_seen, announced, results_seen - announced);
    if (errors == 0) begin
      $display("tb_route_table_update_by_relation_unit: clean");
    end else begin
      $display("tb_route_table_update_by_relation_unit: errors");
    end
    $finish;
  end

  // Result side: random stalls, then compare against the oldest expectation.
  initial begin
    int     stall;
    route_t want;
    route_t got;
    route_ch.ready = 1'b0;
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        route_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      route_ch.ready <= 1'b1;
      do @(posedge clk_i); while (route_ch.valid !== 1'b1);
      got = route_ch.data;
      results_seen++;
      if (pending_routes.size() == 0) begin
        $display("%0t: route for dest %0d arrived with no request outstanding",
                 $time, got.route_dest);
        errors++;
      end else begin
        want = pending_routes.pop_front();
        check_field("announce", 8'(want.announce), 8'(got.announce));
        check_field("route_dest", 8'(want.route_dest), 8'(got.route_dest));
        check_field("route_next_hop", 8'(want.route_next_hop), 8'(got.route_next_hop));
        check_field("route_relation", 8'(want.route_relation), 8'(got.route_relation));
        check_field("route_cost", want.route_cost, got.route_cost);
      end
      if (got.announce === 1'b1) begin
        announced++;
      end
      if (results_seen % 64 == 0) begin
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      @(negedge clk_i);
    end
  end

  // Watchdog: well beyond the table clear plus every request fully stalled.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d routes still expected", $time, pending_routes.size());
    $display("tb_route_table_update_by_relation_unit: errors");
    $finish;
  end

endmodule
